>>> rtl/core/dsl_pkg.sv
// Package for the descending sorted list block.
// Holds the list geometry, operation and status codes, and the types shared by
// the controller, the datapath and the top level. No dependencies.
package dsl_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CW       = $clog2(CAPACITY + 1);
  localparam int unsigned DW       = 32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SORT   = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FULL,
    S_EMPTY,
    S_OUTER,
    S_LOADI,
    S_SCAN,
    S_SWAP1,
    S_SWAP2,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PLACE
  } ctrl_state_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_APPEND,
    DP_CLEAR,
    DP_SORT_INIT,
    DP_INS_INIT,
    DP_OUTER,
    DP_LOADI,
    DP_SCAN,
    DP_SWAP1,
    DP_SWAP2,
    DP_EMIT_INIT,
    DP_EMIT_RD,
    DP_EMIT_OUT,
    DP_INS_RD,
    DP_INS_SHIFT,
    DP_INS_PLACE,
    DP_OUT_FULL,
    DP_OUT_EMPTY
  } dp_cmd_e;

  typedef struct packed {
    logic          full;
    logic          count_zero;
    logic          out_free;
    logic          outer_done;
    logic          scan_last;
    logic          emit_last;
    logic          pos_one;
    logic          value_gt;
    logic [CW-1:0] count;
  } dp_status_t;

endpackage

>>> rtl/core/dsl_ctrl.sv
// Sequencer for the descending sorted list block.
// Walks each request through its steps and issues one datapath command a cycle.
// Depends on dsl_pkg.
module dsl_ctrl import dsl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  dp_status_t status_i,
  output dp_cmd_e    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = DP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (operation_i)
            OP_APPEND: begin
              if (status_i.full) begin
                state_d = S_FULL;
              end else begin
                cmd_o = DP_APPEND;
              end
            end
            OP_SORT: begin
              if (status_i.count_zero) begin
                state_d = S_EMPTY;
              end else begin
                cmd_o   = DP_SORT_INIT;
                state_d = S_OUTER;
              end
            end
            OP_INSERT: begin
              if (status_i.full) begin
                state_d = S_FULL;
              end else begin
                cmd_o   = DP_INS_INIT;
                state_d = status_i.count_zero ? S_INS_PLACE : S_INS_RD;
              end
            end
            default: begin
              cmd_o = DP_CLEAR;
            end
          endcase
        end
      end
      S_FULL: begin
        if (status_i.out_free) begin
          cmd_o   = DP_OUT_FULL;
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o   = DP_OUT_EMPTY;
          state_d = S_IDLE;
        end
      end
      S_OUTER: begin
        if (status_i.outer_done) begin
          cmd_o   = DP_EMIT_INIT;
          state_d = S_EMIT_RD;
        end else begin
          cmd_o   = DP_OUTER;
          state_d = S_LOADI;
        end
      end
      S_LOADI: begin
        cmd_o   = DP_LOADI;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o = DP_SCAN;
        if (status_i.scan_last) begin
          state_d = S_SWAP1;
        end
      end
      S_SWAP1: begin
        cmd_o   = DP_SWAP1;
        state_d = S_SWAP2;
      end
      S_SWAP2: begin
        cmd_o   = DP_SWAP2;
        state_d = S_OUTER;
      end
      S_EMIT_RD: begin
        cmd_o   = DP_EMIT_RD;
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (status_i.out_free) begin
          cmd_o   = DP_EMIT_OUT;
          state_d = status_i.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_INS_RD: begin
        cmd_o   = DP_INS_RD;
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (status_i.value_gt) begin
          cmd_o   = DP_INS_SHIFT;
          state_d = status_i.pos_one ? S_INS_PLACE : S_INS_RD;
        end else begin
          state_d = S_INS_PLACE;
        end
      end
      S_INS_PLACE: begin
        cmd_o   = DP_INS_PLACE;
        state_d = S_EMIT_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/dsl_datapath.sv
// Datapath for the descending sorted list block: value memory, entry count,
// index and compare registers, and the output register. Depends on dsl_pkg.
module dsl_datapath import dsl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_e              cmd_i,
  input  logic signed [DW-1:0] value_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [DW-1:0] item_o,
  output logic                 last_o,
  output logic [1:0]           status_res_o
);

  logic signed [DW-1:0] mem_q [CAPACITY];
  logic signed [DW-1:0] rdata_q;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic signed [DW-1:0] wdata;

  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        i_q, i_d;
  logic [AW-1:0]        j_q, j_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [AW-1:0]        best_idx_q, best_idx_d;
  logic signed [DW-1:0] best_q, best_d;
  logic signed [DW-1:0] tmp_q, tmp_d;
  logic signed [DW-1:0] val_q, val_d;

  logic                 out_valid_q, out_valid_d;
  logic signed [DW-1:0] item_q, item_d;
  logic                 last_q, last_d;
  logic [1:0]           res_q, res_d;

  logic                 out_free;
  logic [AW-1:0]        j_next;

  assign out_free = !out_valid_q || out_ready_i;
  assign j_next   = j_q + AW'(1);

  assign status_o.full       = (count_q == CW'(CAPACITY));
  assign status_o.count_zero = (count_q == '0);
  assign status_o.out_free   = out_free;
  assign status_o.outer_done = ((CW'(i_q) + CW'(1)) >= count_q);
  assign status_o.scan_last  = ((CW'(j_q) + CW'(1)) == count_q);
  assign status_o.emit_last  = ((CW'(i_q) + CW'(1)) == count_q);
  assign status_o.pos_one    = (pos_q == AW'(1));
  assign status_o.value_gt   = (val_q > rdata_q);
  assign status_o.count      = count_q;

  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    waddr       = '0;
    raddr       = '0;
    wdata       = val_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    pos_d       = pos_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    tmp_d       = tmp_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    item_d      = item_q;
    last_d      = last_q;
    res_d       = res_q;
    unique case (cmd_i)
      DP_NOP: begin
      end
      DP_APPEND: begin
        mem_we  = 1'b1;
        waddr   = count_q[AW-1:0];
        wdata   = value_i;
        count_d = count_q + CW'(1);
      end
      DP_CLEAR: begin
        count_d = '0;
      end
      DP_SORT_INIT: begin
        i_d = '0;
      end
      DP_INS_INIT: begin
        pos_d = count_q[AW-1:0];
        val_d = value_i;
      end
      DP_OUTER: begin
        mem_re     = 1'b1;
        raddr      = i_q;
        best_idx_d = i_q;
        j_d        = i_q + AW'(1);
      end
      DP_LOADI: begin
        best_d = rdata_q;
        tmp_d  = rdata_q;
        mem_re = 1'b1;
        raddr  = j_q;
      end
      DP_SCAN: begin
        // rdata_q holds entry j; the next entry is read in the same cycle.
        if (rdata_q > best_q) begin
          best_d     = rdata_q;
          best_idx_d = j_q;
        end
        j_d    = j_next;
        mem_re = 1'b1;
        raddr  = j_next;
      end
      DP_SWAP1: begin
        mem_we = 1'b1;
        waddr  = i_q;
        wdata  = best_q;
      end
      DP_SWAP2: begin
        mem_we = 1'b1;
        waddr  = best_idx_q;
        wdata  = tmp_q;
        i_d    = i_q + AW'(1);
      end
      DP_EMIT_INIT: begin
        i_d = '0;
      end
      DP_EMIT_RD: begin
        mem_re = 1'b1;
        raddr  = i_q;
      end
      DP_EMIT_OUT: begin
        out_valid_d = 1'b1;
        item_d      = rdata_q;
        last_d      = status_o.emit_last;
        res_d       = ST_OK;
        i_d         = i_q + AW'(1);
      end
      DP_INS_RD: begin
        mem_re = 1'b1;
        raddr  = pos_q - AW'(1);
      end
      DP_INS_SHIFT: begin
        mem_we = 1'b1;
        waddr  = pos_q;
        wdata  = rdata_q;
        pos_d  = pos_q - AW'(1);
      end
      DP_INS_PLACE: begin
        mem_we  = 1'b1;
        waddr   = pos_q;
        wdata   = val_q;
        count_d = count_q + CW'(1);
        i_d     = '0;
      end
      DP_OUT_FULL: begin
        out_valid_d = 1'b1;
        item_d      = '0;
        last_d      = 1'b1;
        res_d       = ST_FULL;
      end
      DP_OUT_EMPTY: begin
        out_valid_d = 1'b1;
        item_d      = '0;
        last_d      = 1'b1;
        res_d       = ST_EMPTY;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    pos_q      <= pos_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    tmp_q      <= tmp_d;
    val_q      <= val_d;
    item_q     <= item_d;
    last_q     <= last_d;
    res_q      <= res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign item_o       = item_q;
  assign last_o       = last_q;
  assign status_res_o = res_q;

endmodule

>>> rtl/core/descending_sorted_list_top.sv
// Top level of the descending sorted list block: sequencer plus datapath.
// Depends on dsl_pkg, dsl_ctrl and dsl_datapath.
//
// Keeps up to 64 signed 32-bit values in a single-port-write, registered-read
// memory. Append and clear need no further steps once taken. Sort is a selection
// sort on the memory: each pass i reads entry i, scans the later entries for the
// largest, then writes the two entries swapped; the emit follows. Insert compares
// the new value with the entry ahead of its slot, shifts each smaller entry one
// slot toward the end, stops at an entry that is not smaller or at the front,
// writes the value, then emits. Emit delivers each result with one memory read
// and one output load, waiting while the consumer does not keep up. A full list
// drops the value and gives a single result with status full; emitting an empty
// list gives one result with status empty. The last result of every run has
// last set. A new request is taken only after the previous one has finished
// its work; a result still held in the output register does not block that.
module descending_sorted_list_top import dsl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic signed [DW-1:0] value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [DW-1:0] item_o,
  output logic                 last_o,
  output logic [1:0]           status_o
);

  dp_cmd_e    cmd;
  dp_status_t dp_status;

  dsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  dsl_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (value_i),
    .status_o     (dp_status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .item_o       (item_o),
    .last_o       (last_o),
    .status_res_o (status_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_status.count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_status_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o && (item_o == '0))
    else $error("status result without last or with nonzero item");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == OP_APPEND) && !dp_status.full
    |=> dp_status.count == $past(dp_status.count) + CW'(1))
    else $error("append did not grow the list by one");

  a_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == OP_CLEAR) |=> dp_status.count_zero)
    else $error("clear left entries in the list");

endmodule

>>> tb/sv/descending_sorted_list_top_tb.sv
// Self-checking testbench for descending_sorted_list_top: a directed table, then random
// request sequences, checked result by result against a predictor of the sorted list.
// Depends on dsl_pkg and the RTL of descending_sorted_list_top.
module descending_sorted_list_top_tb import dsl_pkg::*; ();

  localparam int unsigned TOTAL_ITEMS  = 310;
  localparam int unsigned CALM_ITEMS   = 40;
  localparam longint      CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [DW-1:0] item;
    logic                 last;
    logic [1:0]           status;
  } result_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [DW-1:0] value;
    bit            rnd;
    logic [6:0]    reps;
    bit            typed;
    result_t       res;
  } stim_row_t;

  localparam result_t NO_RES = '0;
  localparam int unsigned NDIR = 25;

  localparam stim_row_t DIRECTED [NDIR] = '{
    '{OP_SORT,   32'h0000_0000, 1'b0, 7'd1,  1'b1, '{32'sd0, 1'b1, ST_EMPTY}},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, 7'd1,  1'b1, '{32'sh7FFF_FFFF, 1'b1, ST_OK}},
    '{OP_APPEND, 32'h8000_0000, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_APPEND, 32'h0000_0000, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_APPEND, 32'hFFFF_FFFF, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_SORT,   32'h1234_5678, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_INSERT, 32'h0000_0001, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_INSERT, 32'h8000_0000, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_APPEND, 32'h0000_0005, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_INSERT, 32'h0000_0003, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_CLEAR,  32'hDEAD_BEEF, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_SORT,   32'hFFFF_FFFF, 1'b0, 7'd1,  1'b1, '{32'sd0, 1'b1, ST_EMPTY}},
    '{OP_APPEND, 32'h5555_5555, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_APPEND, 32'hAAAA_AAAA, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_CLEAR,  32'h0000_0000, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_APPEND, 32'h0000_0000, 1'b1, 7'd63, 1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_INSERT, 32'h0000_0000, 1'b1, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_APPEND, 32'h0000_1234, 1'b0, 7'd1,  1'b1, '{32'sd0, 1'b1, ST_FULL}},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, 7'd1,  1'b1, '{32'sd0, 1'b1, ST_FULL}},
    '{OP_SORT,   32'h0000_0000, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_SORT,   32'h0000_0000, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_CLEAR,  32'hFFFF_FFFF, 1'b0, 7'd1,  1'b0, '{32'sd0, 1'b0, ST_OK}},
    '{OP_INSERT, 32'h8000_0000, 1'b0, 7'd1,  1'b1, '{32'sh8000_0000, 1'b1, ST_OK}}
  };

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           operation_i = OP_APPEND;
  logic signed [DW-1:0] value_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [DW-1:0] item_o;
  logic                 last_o;
  logic [1:0]           status_o;

  descending_sorted_list_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .item_o     (item_o),
    .last_o     (last_o),
    .status_o   (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predicted list contents and the results still owed by the block.
  logic signed [DW-1:0] list_vals [CAPACITY];
  int unsigned          list_len = 0;
  result_t              run_q [$];
  result_t              expected_q [$];

  bit          idle_on         = 1'b1;
  int unsigned stall_left      = 0;
  int unsigned errors          = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned full_seen       = 0;
  int unsigned empty_seen      = 0;
  int unsigned longest_list    = 0;
  longint      cycles          = 0;
  result_t     front_res;

  function automatic result_t make_result(logic signed [DW-1:0] item, logic last,
                                          logic [1:0] status);
    result_t r;
    r.item   = item;
    r.last   = last;
    r.status = status;
    return r;
  endfunction

  function automatic logic signed [DW-1:0] random_value();
    logic signed [DW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = {1'b1, {(DW-1){1'b0}}};
      1: v = {1'b0, {(DW-1){1'b1}}};
      2: begin
        // A narrow range makes equal values common.
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic emit_list_run();
    if (list_len == 0) begin
      run_q.push_back(make_result('0, 1'b1, ST_EMPTY));
      empty_seen++;
    end else begin
      for (int unsigned i = 0; i < list_len; i++)
        run_q.push_back(make_result(list_vals[i], (i + 1 == list_len), ST_OK));
    end
  endtask

  task automatic predict_list_op(input logic [1:0] op, input logic signed [DW-1:0] v);
    int unsigned pos;
    int unsigned best;
    logic signed [DW-1:0] t;
    run_q.delete();
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          run_q.push_back(make_result('0, 1'b1, ST_FULL));
          full_seen++;
        end else begin
          list_vals[list_len] = v;
          list_len++;
        end
      end
      OP_SORT: begin
        for (int unsigned i = 0; i < list_len; i++) begin
          best = i;
          for (int unsigned j = i + 1; j < list_len; j++)
            if (list_vals[j] > list_vals[best]) best = j;
          t               = list_vals[i];
          list_vals[i]    = list_vals[best];
          list_vals[best] = t;
        end
        emit_list_run();
      end
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          run_q.push_back(make_result('0, 1'b1, ST_FULL));
          full_seen++;
        end else begin
          // Smaller entries move back one slot; equal ones stay ahead.
          pos = list_len;
          while (pos > 0 && v > list_vals[pos-1]) begin
            list_vals[pos] = list_vals[pos-1];
            pos--;
          end
          list_vals[pos] = v;
          list_len++;
          emit_list_run();
        end
      end
      default: list_len = 0;
    endcase
    if (list_len > longest_list) longest_list = list_len;
  endtask

  task automatic send_request(input logic [1:0] op, input logic signed [DW-1:0] v,
                              input bit use_typed, input result_t typed_res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    do @(posedge clk_i); while (!in_ready_o);
    predict_list_op(op, v);
    if (use_typed) begin
      run_q.delete();
      run_q.push_back(typed_res);
    end
    foreach (run_q[i]) expected_q.push_back(run_q[i]);
    requests_sent++;
  endtask

  // Lower the request and hold off until every owed result has arrived.
  task automatic hold_off();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: item %0d last %0b status %0d",
                 $time, item_o, last_o, status_o);
        errors++;
      end else begin
        front_res = expected_q.pop_front();
        results_checked++;
        if (item_o !== front_res.item) begin
          $display("%0t: item mismatch: expected %0d, actual %0d",
                   $time, front_res.item, item_o);
          errors++;
        end
        if (last_o !== front_res.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, front_res.last, last_o);
          errors++;
        end
        if (status_o !== front_res.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, front_res.status, status_o);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("descending_sorted_list_top test failed");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    logic signed [DW-1:0] v;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NDIR; r++) begin
      for (int k = 0; k < DIRECTED[r].reps; k++) begin
        v = DIRECTED[r].rnd ? random_value() : DIRECTED[r].value;
        send_request(DIRECTED[r].op, v, DIRECTED[r].typed, DIRECTED[r].res);
      end
    end
    hold_off();

    // Mostly well-formed runs: maybe clear, fill, maybe insert, sort, then inserts into the list.
    while (requests_sent < TOTAL_ITEMS) begin
      if (requests_sent + CALM_ITEMS >= TOTAL_ITEMS) idle_on = 1'b0;
      if (idle_on && $urandom_range(0, 9) == 0) hold_off();
      if ($urandom_range(0, 9) < 2) begin
        n = $urandom_range(1, 4);
        repeat (n) send_request(2'($urandom_range(0, 3)), random_value(), 1'b0, NO_RES);
      end else begin
        if ($urandom_range(0, 3) != 0) send_request(OP_CLEAR, random_value(), 1'b0, NO_RES);
        pick = $urandom_range(0, 19);
        if (pick < 17)      n = $urandom_range(0, 8);
        else if (pick < 19) n = $urandom_range(9, 40);
        else                n = $urandom_range(60, 68);
        if (n > TOTAL_ITEMS - requests_sent) n = TOTAL_ITEMS - requests_sent;
        repeat (n) send_request(OP_APPEND, random_value(), 1'b0, NO_RES);
        if ($urandom_range(0, 2) == 0) send_request(OP_INSERT, random_value(), 1'b0, NO_RES);
        send_request(OP_SORT, random_value(), 1'b0, NO_RES);
        n = $urandom_range(0, 3);
        repeat (n) send_request(OP_INSERT, random_value(), 1'b0, NO_RES);
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results; longest list %0d entries.",
             requests_sent, results_checked, longest_list);
    $display("Saw %0d list-full drops and %0d empty-list emits.", full_seen, empty_seen);
    if (errors == 0) begin
      $display("descending_sorted_list_top test passed");
    end else begin
      $display("descending_sorted_list_top test failed");
    end
    $finish;
  end

endmodule
